// ===== rtl/lcfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcfc_pkg
// Shared types, constants and colour helpers of the lamp channel frame
// compositor: opcodes, register indexes, wire orders and byte scaling.
// ----------------------------------------------------------------------------
package lcfc_pkg;

    localparam int MAX_LEDS     = 256;
    localparam int MAX_CHANNELS = 256;
    localparam logic [23:0] DEFAULT_TINT = 24'hFF_FFFF;

    localparam int LED_AW     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CH_AW      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W      = 16;
    localparam int CNT_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int TARGET_W   = 10;
    localparam int RGB_W      = 24;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_START_FRAME = 2'd0,
        OP_LEVEL       = 2'd1,
        OP_SET_MAP     = 2'd2,
        OP_READ_PIXEL  = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_LEDS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVR_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVR_LED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVR_RGB    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVR_LEVEL  = 3'd6;

    localparam logic [2:0] ORDER_RGB = 3'd0;
    localparam logic [2:0] ORDER_RBG = 3'd1;
    localparam logic [2:0] ORDER_GRB = 3'd2;
    localparam logic [2:0] ORDER_GBR = 3'd3;
    localparam logic [2:0] ORDER_BRG = 3'd4;
    localparam logic [2:0] ORDER_BGR = 3'd5;

    typedef struct packed {
        logic [BYTE_W-1:0]   pixel;
        logic [BYTE_W-1:0]   tint_blue;
        logic [BYTE_W-1:0]   tint_green;
        logic [BYTE_W-1:0]   tint_red;
        logic [TARGET_W-1:0] target_led;
        logic [BYTE_W-1:0]   level;
        logic [BYTE_W-1:0]   channel;
        op_t                 opcode;
    } item_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [RGB_W-1:0]    tint;
    } map_entry_t;

    // floor(v*s/255) by reciprocal: exact for products up to 255*255
    function automatic logic [BYTE_W-1:0] scale_byte(input logic [BYTE_W-1:0] v,
                                                     input logic [BYTE_W-1:0] s);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = 16'(v) * 16'(s);
        sum  = 17'(prod) + 17'(prod[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

    // wire byte 0 in bits 7:0, byte 1 in 15:8, byte 2 in 23:16
    function automatic logic [RGB_W-1:0] pack_order(input logic [BYTE_W-1:0] r,
                                                    input logic [BYTE_W-1:0] g,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [2:0] order);
        logic [RGB_W-1:0] packed_bytes;
        case (order)
            ORDER_RBG: packed_bytes = {g, b, r};
            ORDER_GRB: packed_bytes = {b, r, g};
            ORDER_GBR: packed_bytes = {r, b, g};
            ORDER_BRG: packed_bytes = {g, r, b};
            ORDER_BGR: packed_bytes = {r, g, b};
            default:   packed_bytes = {b, g, r};
        endcase
        return packed_bytes;
    endfunction

endpackage

// ===== rtl/lamp_channel_frame_compositor.sv =====
// ----------------------------------------------------------------------------
// lamp_channel_frame_compositor
// Composes an RGB LED frame from per-channel brightness levels through a
// channel map, and answers pixel read-back requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one request per beat: s_tuser holds the opcode, s_tdata
//   the operands. Every request gives exactly one result on the m_ channel:
//   m_tuser is the status flag, m_tdata the three wire bytes (zero unless the
//   request was a pixel read).
//   The cfg channel writes the setup registers; it is always ready and is
//   meant to be used while no request is in flight.
//   A request passes the input register, then the result register. One request is
//   taken every cycle unless the result side stalls; the map and frame memories are
//   read at the request edge, the frame memory is written as the request leaves the
//   input register; a read right behind a level write uses a bypass of that write.
//   Reset returns the map to its identity entries with full white tint (by
//   per-entry valid bits, no clearing pass) and marks every pixel dark.
//   When the receiver stalls, the result register holds, one more request is
//   taken into the input register, and s_tready then drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module lamp_channel_frame_compositor (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // channel[7:0], level[15:8], target_led[25:16], tint_red[33:26],
    // tint_green[41:34], tint_blue[49:42], pixel[57:50], zero[63:58]
    input  logic [lcfc_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // wire_byte0[7:0], wire_byte1[15:8], wire_byte2[23:16]
    output logic [lcfc_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[0]
    output logic                              m_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lcfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcfc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LED_AW = lcfc_pkg::LED_AW;
    localparam int CH_AW  = lcfc_pkg::CH_AW;
    localparam int CMP_W  = lcfc_pkg::CMP_W;

    // setup registers
    logic [lcfc_pkg::CNT_W-1:0]  leds_cfg_reg;
    logic [lcfc_pkg::CNT_W-1:0]  chans_cfg_reg;
    logic [2:0]                  order_reg;
    logic                        ovr_on_reg;
    logic [15:0]                 ovr_led_reg;
    logic [lcfc_pkg::RGB_W-1:0]  ovr_rgb_reg;
    logic [lcfc_pkg::BYTE_W-1:0] ovr_level_reg;

    // memories and their per-entry flags
    lcfc_pkg::map_entry_t          map_mem_reg   [lcfc_pkg::MAX_CHANNELS];
    logic [lcfc_pkg::RGB_W-1:0]    frame_mem_reg [lcfc_pkg::MAX_LEDS];
    logic [lcfc_pkg::MAX_CHANNELS-1:0] map_valid_reg;
    logic [lcfc_pkg::MAX_LEDS-1:0]     lit_reg, lit_next;

    // pipeline
    lcfc_pkg::item_t             in_item;
    lcfc_pkg::item_t             s1_item_reg;
    logic                        s1_valid_reg;
    lcfc_pkg::map_entry_t        map_rd_reg;
    logic                        map_hit_reg;
    logic [lcfc_pkg::RGB_W-1:0]  frame_rd_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [lcfc_pkg::RGB_W-1:0]  m_tdata_reg;
    logic                        m_tuser_reg;

    // last frame write, for a read issued on the same edge
    logic                        fwd_valid_reg, fwd_valid_next;
    logic [LED_AW-1:0]           fwd_addr_reg, fwd_addr_next;
    logic [lcfc_pkg::RGB_W-1:0]  fwd_data_reg, fwd_data_next;

    logic                        accept;
    logic                        advance;
    logic [CMP_W-1:0]            leds_eff;
    logic [CMP_W-1:0]            chans_eff;
    logic                        in_ch_ok;
    logic [CH_AW-1:0]            in_ch_idx;
    logic [LED_AW-1:0]           in_px_idx;

    lcfc_pkg::map_entry_t        map_entry;
    logic                        s1_ch_ok;
    logic                        tgt_ok;
    logic [LED_AW-1:0]           wr_addr;
    logic                        px_ok;
    logic [LED_AW-1:0]           s1_px_idx;
    logic                        ovr_hit;
    logic                        is_read;
    logic [lcfc_pkg::RGB_W-1:0]  src_rgb;
    logic [lcfc_pkg::BYTE_W-1:0] src_lv;
    logic [lcfc_pkg::RGB_W-1:0]  scaled;
    logic                        frame_wr;
    logic                        start_adv;
    logic                        fwd_hit;
    logic [lcfc_pkg::RGB_W-1:0]  stored;
    logic                        res_status;
    logic [lcfc_pkg::RGB_W-1:0]  res_bytes;

    assign cfg_ready = 1'b1;

    always_comb begin
        in_item.opcode     = lcfc_pkg::op_t'(s_tuser);
        in_item.channel    = s_tdata[7:0];
        in_item.level      = s_tdata[15:8];
        in_item.target_led = s_tdata[25:16];
        in_item.tint_red   = s_tdata[33:26];
        in_item.tint_green = s_tdata[41:34];
        in_item.tint_blue  = s_tdata[49:42];
        in_item.pixel      = s_tdata[57:50];
    end

    assign advance  = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign leds_eff  = (CMP_W'(leds_cfg_reg) < CMP_W'(lcfc_pkg::MAX_LEDS)) ?
                       CMP_W'(leds_cfg_reg) : CMP_W'(lcfc_pkg::MAX_LEDS);
    assign chans_eff = (CMP_W'(chans_cfg_reg) < CMP_W'(lcfc_pkg::MAX_CHANNELS)) ?
                       CMP_W'(chans_cfg_reg) : CMP_W'(lcfc_pkg::MAX_CHANNELS);

    assign in_ch_ok  = CMP_W'(in_item.channel) < chans_eff;
    assign in_ch_idx = CH_AW'(in_item.channel);
    assign in_px_idx = LED_AW'(in_item.pixel);

    // setup register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leds_cfg_reg  <= lcfc_pkg::CNT_W'(256);
            chans_cfg_reg <= lcfc_pkg::CNT_W'(256);
            order_reg     <= lcfc_pkg::ORDER_RGB;
            ovr_on_reg    <= 1'b0;
            ovr_led_reg   <= '0;
            ovr_rgb_reg   <= '0;
            ovr_level_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcfc_pkg::CFG_LEDS:       leds_cfg_reg  <= cfg_data[8:0];
                lcfc_pkg::CFG_CHANNELS:   chans_cfg_reg <= cfg_data[8:0];
                lcfc_pkg::CFG_BYTE_ORDER: order_reg     <= cfg_data[2:0];
                lcfc_pkg::CFG_OVR_ON:     ovr_on_reg    <= cfg_data[0];
                lcfc_pkg::CFG_OVR_LED:    ovr_led_reg   <= cfg_data[15:0];
                lcfc_pkg::CFG_OVR_RGB:    ovr_rgb_reg   <= cfg_data[23:0];
                lcfc_pkg::CFG_OVR_LEVEL:  ovr_level_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // map memory: written and read at the request edge
    always_ff @(posedge aclk) begin
        if (accept) begin
            map_rd_reg  <= map_mem_reg[in_ch_idx];
            map_hit_reg <= map_valid_reg[in_ch_idx];
            if (in_item.opcode == lcfc_pkg::OP_SET_MAP && in_ch_ok) begin
                map_mem_reg[in_ch_idx].target <= in_item.target_led;
                map_mem_reg[in_ch_idx].tint   <= {in_item.tint_blue, in_item.tint_green,
                                                  in_item.tint_red};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_valid_reg <= '0;
        end else if (accept && in_item.opcode == lcfc_pkg::OP_SET_MAP && in_ch_ok) begin
            map_valid_reg[in_ch_idx] <= 1'b1;
        end
    end

    // frame memory: read at the request edge, written as the level leaves stage one
    always_ff @(posedge aclk) begin
        if (accept) begin
            frame_rd_reg <= frame_mem_reg[in_px_idx];
        end
        if (frame_wr) begin
            frame_mem_reg[wr_addr] <= scaled;
        end
    end

    // stage one: decode, scale and pick the result
    always_comb begin
        if (map_hit_reg) begin
            map_entry = map_rd_reg;
        end else begin
            map_entry.target = lcfc_pkg::TARGET_W'(s1_item_reg.channel);
            map_entry.tint   = lcfc_pkg::DEFAULT_TINT;
        end

        s1_ch_ok  = CMP_W'(s1_item_reg.channel) < chans_eff;
        tgt_ok    = !map_entry.target[lcfc_pkg::TARGET_W-1] &&
                    (CMP_W'(map_entry.target) < leds_eff);
        wr_addr   = LED_AW'(map_entry.target);
        px_ok     = CMP_W'(s1_item_reg.pixel) < leds_eff;
        s1_px_idx = LED_AW'(s1_item_reg.pixel);
        ovr_hit   = ovr_on_reg && (ovr_led_reg == 16'(s1_item_reg.pixel));

        // one scaler serves both the level write and the override read
        is_read = s1_item_reg.opcode == lcfc_pkg::OP_READ_PIXEL;
        src_rgb = is_read ? ovr_rgb_reg : map_entry.tint;
        src_lv  = is_read ? ovr_level_reg : s1_item_reg.level;
        scaled  = lcfc_pkg::pack_order(lcfc_pkg::scale_byte(src_rgb[7:0], src_lv),
                                       lcfc_pkg::scale_byte(src_rgb[15:8], src_lv),
                                       lcfc_pkg::scale_byte(src_rgb[23:16], src_lv),
                                       order_reg);

        frame_wr  = advance && (s1_item_reg.opcode == lcfc_pkg::OP_LEVEL) &&
                    s1_ch_ok && tgt_ok;
        start_adv = advance && (s1_item_reg.opcode == lcfc_pkg::OP_START_FRAME);

        fwd_hit = fwd_valid_reg && (fwd_addr_reg == s1_px_idx);
        if (!lit_reg[s1_px_idx]) begin
            stored = '0;
        end else if (fwd_hit) begin
            stored = fwd_data_reg;
        end else begin
            stored = frame_rd_reg;
        end

        res_status = 1'b0;
        res_bytes  = '0;
        case (s1_item_reg.opcode)
            lcfc_pkg::OP_START_FRAME: ;
            lcfc_pkg::OP_LEVEL,
            lcfc_pkg::OP_SET_MAP: begin
                res_status = !s1_ch_ok;
            end
            lcfc_pkg::OP_READ_PIXEL: begin
                if (!px_ok) begin
                    res_status = 1'b1;
                end else if (ovr_hit) begin
                    res_bytes = scaled;
                end else begin
                    res_bytes = stored;
                end
            end
            default: ;
        endcase
    end

    // dark marks and write bypass
    always_comb begin
        lit_next       = lit_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next  = fwd_addr_reg;
        fwd_data_next  = fwd_data_reg;
        if (start_adv) begin
            lit_next       = '0;
            fwd_valid_next = 1'b0;
        end else if (frame_wr) begin
            lit_next[wr_addr] = 1'b1;
            fwd_valid_next    = 1'b1;
            fwd_addr_next     = wr_addr;
            fwd_data_next     = scaled;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            lit_reg       <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            m_tvalid_reg  <= m_tvalid_next;
            lit_reg       <= lit_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg <= in_item;
        end
        if (advance) begin
            m_tdata_reg <= res_bytes;
            m_tuser_reg <= res_status;
        end
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // the input side only waits on a stalled result
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input not ready although the result side is free");

    // a start of frame darkens every pixel
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        start_adv |=> (lit_reg == '0) && !fwd_valid_reg)
        else $error("pixels still lit after start of frame");

    // the bypass only ever holds a pixel that is lit
    a_bypass_lit: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_valid_reg |-> lit_reg[fwd_addr_reg])
        else $error("write bypass points at a dark pixel");

endmodule
